// File: src/ntp_pkg.sv
package ntp_pkg;

	localparam int EXP_LIMIT_DEF = 1024;
	localparam int SIG_W = 64;
	localparam int PEXP_W = 13;
	localparam int PEXP_MAX = 2048;
	localparam int RADIX_W = 6;
	localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_POINT = 8'h2E;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_A_UP = 8'h41;
	localparam logic [7:0] CH_Z_UP = 8'h5A;
	localparam logic [7:0] CH_A_LO = 8'h61;
	localparam logic [7:0] CH_Z_LO = 8'h7A;
	localparam logic [7:0] CH_D_UP = 8'h44;
	localparam logic [7:0] CH_E_UP = 8'h45;
	localparam logic [7:0] CH_D_LO = 8'h64;
	localparam logic [7:0] CH_E_LO = 8'h65;

	typedef enum logic [1:0] {
		KIND_INT  = 2'd0,
		KIND_REAL = 2'd1,
		KIND_NAN  = 2'd2
	} ntp_kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCALE,
		ST_EMIT
	} ntp_state_t;

	typedef struct packed {
		logic char_step;
		logic term_load;
		logic scale_step;
		logic out_load;
	} ntp_cmd_t;

	typedef struct packed {
		logic is_term;
		logic scale_done;
	} ntp_status_t;

	// {valid, value}; letters count from ten, case folded
	function automatic logic [RADIX_W:0] digit_of(input logic [7:0] ch,
			input logic [RADIX_W-1:0] radix);
		logic [7:0] v;
		logic hit;
		begin
			v = 8'd0;
			hit = 1'b1;
			if (ch >= CH_ZERO && ch <= CH_NINE) begin
				v = ch - CH_ZERO;
			end else if (ch >= CH_A_UP && ch <= CH_Z_UP) begin
				v = ch - CH_A_UP + 8'd10;
			end else if (ch >= CH_A_LO && ch <= CH_Z_LO) begin
				v = ch - CH_A_LO + 8'd10;
			end else begin
				hit = 1'b0;
			end
			digit_of = {hit && (v[RADIX_W-1:0] < radix), v[RADIX_W-1:0]};
		end
	endfunction

endpackage

// File: src/ntp_in_if.sv
interface ntp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;

	modport source (output valid, output char_code, input ready);
	modport sink (input valid, input char_code, output ready);
endinterface

// File: src/ntp_out_if.sv
interface ntp_out_if;
	logic               valid;
	logic               ready;
	logic [1:0]         number_kind;
	logic               is_negative;
	logic signed [31:0] int_value;
	logic [63:0]        significand;
	logic signed [12:0] power_exponent;
	logic               saturated;

	modport source (output valid, output number_kind, output is_negative, output int_value,
		output significand, output power_exponent, output saturated, input ready);
	modport sink (input valid, input number_kind, input is_negative, input int_value,
		input significand, input power_exponent, input saturated, output ready);
endinterface

// File: src/ntp_ctrl.sv
module ntp_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  ntp_pkg::ntp_status_t status,
	output ntp_pkg::ntp_cmd_t    cmd
);
	import ntp_pkg::*;

	ntp_state_t state_q, state_d;
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && status.is_term) state_d = ST_SCALE;
			end
			ST_SCALE: begin
				if (status.scale_done) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (!out_valid_q || out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.char_step = in_valid && !status.is_term;
				cmd.term_load = in_valid && status.is_term;
			end
			ST_SCALE: begin
				cmd.scale_step = !status.scale_done;
			end
			ST_EMIT: begin
				cmd.out_load = !out_valid_q || out_ready;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// output slot: a new result may replace one taken in the same cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// File: src/ntp_datapath.sv
module ntp_datapath #(
	parameter int EXP_LIMIT = ntp_pkg::EXP_LIMIT_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ntp_pkg::ntp_cmd_t           cmd,
	output ntp_pkg::ntp_status_t        status,
	input  logic [7:0]                  char_code,
	input  logic [ntp_pkg::RADIX_W-1:0] radix,
	output logic [1:0]                  number_kind,
	output logic                        is_negative,
	output logic signed [31:0]          int_value,
	output logic [ntp_pkg::SIG_W-1:0]   significand,
	output logic signed [ntp_pkg::PEXP_W-1:0] power_exponent,
	output logic                        saturated
);
	import ntp_pkg::*;

	localparam int ExpW = $clog2(EXP_LIMIT + 1);
	localparam int ExpProdW = ExpW + RADIX_W + 1;
	localparam int PW = (ExpW + 2 > PEXP_W + 1) ? ExpW + 2 : PEXP_W + 1;
	localparam logic [ExpW-1:0] ExpLim = ExpW'(EXP_LIMIT);
	localparam logic signed [PW-1:0] PMax = PW'(PEXP_MAX);
	localparam logic signed [PW-1:0] PMin = -PW'(PEXP_MAX);
	localparam logic [32:0] IntCap = 33'h1_0000_0000;
	localparam logic [32:0] NegMax = 33'h0_8000_0000;
	localparam logic [32:0] PosMax = 33'h0_7FFF_FFFF;

	// parse state
	logic first_q, minus_q, point_q, exp_q, just_q, expneg_q, bad_q, clip_q;
	logic [SIG_W-1:0] acc_q;
	logic [ExpW-1:0] expacc_q, frac_q;

	// result under construction
	ntp_kind_t res_kind_q;
	logic res_neg_q, res_sat_q;
	logic [SIG_W-1:0] res_sig_q;
	logic [PEXP_W-1:0] res_pexp_q;
	logic [32:0] m_q;
	logic [ExpW-1:0] cnt_q;

	// output register
	logic [1:0] kind_q;
	logic neg_q, sat_q;
	logic [31:0] ival_q;
	logic [SIG_W-1:0] sig_q;
	logic [PEXP_W-1:0] pexp_q;

	logic [RADIX_W:0] dig;
	logic dig_ok, is_marker;
	logic [SIG_W+RADIX_W-1:0] acc_prod;
	logic [SIG_W+RADIX_W:0] acc_sum;
	logic acc_ovf;
	logic [ExpProdW-1:0] exp_sum;
	logic signed [PW-1:0] e_s, f_s, p_s;
	logic [PEXP_W-1:0] p_clamped;
	logic p_clip;
	logic [38:0] m_prod;
	logic [32:0] m_scaled, m_neg, m_pos;
	logic [31:0] ival_d;
	logic ival_clip;

	always_comb begin
		dig = digit_of(char_code, radix);
		dig_ok = dig[RADIX_W];
		is_marker = char_code == CH_E_LO || char_code == CH_E_UP ||
			char_code == CH_D_LO || char_code == CH_D_UP;
		acc_prod = (SIG_W+RADIX_W)'(acc_q) * (SIG_W+RADIX_W)'(radix);
		acc_sum = {1'b0, acc_prod} + (SIG_W+RADIX_W+1)'(dig[RADIX_W-1:0]);
		acc_ovf = |acc_sum[SIG_W+RADIX_W:SIG_W];
		exp_sum = ExpProdW'(expacc_q) * ExpProdW'(radix) + ExpProdW'(dig[RADIX_W-1:0]);
	end

	// power of radix for reals
	always_comb begin
		e_s = $signed(PW'(expacc_q));
		f_s = $signed(PW'(frac_q));
		p_s = (expneg_q ? -e_s : e_s) - f_s;
		p_clip = 1'b0;
		if (p_s > PMax) begin
			p_clamped = PEXP_W'(PMax);
			p_clip = 1'b1;
		end else if (p_s < PMin) begin
			p_clamped = PEXP_W'(PMin);
			p_clip = 1'b1;
		end else begin
			p_clamped = PEXP_W'(p_s);
		end
	end

	// one radix multiply per scaling step, pinned at 2^32
	always_comb begin
		m_prod = 39'(m_q) * 39'(radix);
		m_scaled = (m_prod > 39'(IntCap)) ? IntCap : m_prod[32:0];
	end

	assign status.is_term = char_code == CH_NUL;
	assign status.scale_done = cnt_q == '0 || m_q == '0 || m_q[32] ||
		radix == RADIX_W'(1);

	always_comb begin
		m_neg = (m_q > NegMax) ? NegMax : m_q;
		m_pos = (m_q > PosMax) ? PosMax : m_q;
		ival_clip = res_neg_q ? (m_q > NegMax) : (m_q > PosMax);
		ival_d = res_neg_q ? 32'(33'd0 - m_neg) : m_pos[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b1;
			minus_q <= 1'b0;
			point_q <= 1'b0;
			exp_q <= 1'b0;
			just_q <= 1'b0;
			expneg_q <= 1'b0;
			bad_q <= 1'b0;
			clip_q <= 1'b0;
			acc_q <= '0;
			expacc_q <= '0;
			frac_q <= '0;
		end else if (cmd.term_load) begin
			first_q <= 1'b1;
			minus_q <= 1'b0;
			point_q <= 1'b0;
			exp_q <= 1'b0;
			just_q <= 1'b0;
			expneg_q <= 1'b0;
			bad_q <= 1'b0;
			clip_q <= 1'b0;
			acc_q <= '0;
			expacc_q <= '0;
			frac_q <= '0;
		end else if (cmd.char_step && !bad_q) begin
			first_q <= 1'b0;
			if (first_q && (char_code == CH_MINUS || char_code == CH_PLUS)) begin
				minus_q <= char_code == CH_MINUS;
			end else begin
				just_q <= 1'b0;
				if (char_code == CH_POINT && !point_q && !exp_q) begin
					point_q <= 1'b1;
				end else if (!exp_q && is_marker) begin
					exp_q <= 1'b1;
					just_q <= 1'b1;
				end else if (exp_q && just_q && char_code == CH_MINUS) begin
					expneg_q <= 1'b1;
					point_q <= 1'b1;
				end else if (exp_q && just_q && char_code == CH_PLUS) begin
					expneg_q <= 1'b0;
				end else if (!dig_ok) begin
					bad_q <= 1'b1;
				end else if (!exp_q) begin
					if (acc_ovf) begin
						acc_q <= '1;
						clip_q <= 1'b1;
					end else begin
						acc_q <= acc_sum[SIG_W-1:0];
					end
					// fraction count clips but digits keep going
					if (point_q) begin
						if (frac_q >= ExpLim) begin
							clip_q <= 1'b1;
						end else begin
							frac_q <= frac_q + 1'b1;
						end
					end
				end else begin
					if (exp_sum > ExpProdW'(EXP_LIMIT)) begin
						expacc_q <= ExpLim;
						clip_q <= 1'b1;
					end else begin
						expacc_q <= exp_sum[ExpW-1:0];
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.term_load) begin
			res_neg_q <= minus_q;
			res_sig_q <= '0;
			res_pexp_q <= '0;
			res_sat_q <= 1'b0;
			m_q <= '0;
			cnt_q <= '0;
			if (bad_q) begin
				res_kind_q <= KIND_NAN;
			end else if (point_q) begin
				res_kind_q <= KIND_REAL;
				res_sig_q <= acc_q;
				res_pexp_q <= p_clamped;
				res_sat_q <= clip_q || p_clip;
			end else begin
				res_kind_q <= KIND_INT;
				res_sat_q <= clip_q;
				m_q <= (acc_q > SIG_W'(IntCap)) ? IntCap : acc_q[32:0];
				cnt_q <= exp_q ? expacc_q : '0;
			end
		end else if (cmd.scale_step) begin
			m_q <= m_scaled;
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			kind_q <= res_kind_q;
			neg_q <= res_neg_q;
			sig_q <= res_sig_q;
			pexp_q <= res_pexp_q;
			if (res_kind_q == KIND_INT) begin
				ival_q <= ival_d;
				sat_q <= res_sat_q || ival_clip;
			end else begin
				ival_q <= '0;
				sat_q <= res_sat_q;
			end
		end
	end

	assign number_kind = kind_q;
	assign is_negative = neg_q;
	assign int_value = $signed(ival_q);
	assign significand = sig_q;
	assign power_exponent = $signed(pexp_q);
	assign saturated = sat_q;

endmodule

// File: src/numeric_text_to_number_parser.sv
// Character-serial number parser.
// in_ch carries one ASCII character per beat; a zero byte ends the string.
// out_ch carries one result beat per string: kind (integer, real, illegal),
// sign, 32-bit integer value, 64-bit significand with a power-of-radix
// exponent, and a saturation flag.
// radix_we/radix_wdata write the number base (reset value 10); write it only
// while no string is in flight.
// Ordinary characters are taken one per cycle while idle and give no result.
// The result of a terminator is built in the scale state and loaded into the
// output register from the emit state; in_ch is ready again when it is valid
// on out_ch. The scale state does k radix multiplications that scale an
// integer with a positive exponent: one 33 x 6 multiply per cycle, stopping
// at zero, at 2^32, at radix 1 or when the exponent count runs out (k <= 32).
// in_ch is not ready from the terminator until the result sits in the output
// register; characters of the next string are taken while it waits there.
// A stall on out_ch holds the result; a second terminator then waits
// in the emit state until the first result is taken.
// Reset clears the parse state, empties the output register and sets radix 10.
module numeric_text_to_number_parser #(
	parameter int EXP_LIMIT = ntp_pkg::EXP_LIMIT_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        radix_we,
	input  logic [ntp_pkg::RADIX_W-1:0] radix_wdata,
	ntp_in_if.sink                      in_ch,
	ntp_out_if.source                   out_ch
);
	import ntp_pkg::*;

	logic [RADIX_W-1:0] radix_q;
	ntp_cmd_t cmd;
	ntp_status_t status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (radix_we) begin
			radix_q <= radix_wdata;
		end
	end

	ntp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.status    (status),
		.cmd       (cmd)
	);

	ntp_datapath #(
		.EXP_LIMIT (EXP_LIMIT)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.char_code      (in_ch.char_code),
		.radix          (radix_q),
		.number_kind    (out_ch.number_kind),
		.is_negative    (out_ch.is_negative),
		.int_value      (out_ch.int_value),
		.significand    (out_ch.significand),
		.power_exponent (out_ch.power_exponent),
		.saturated      (out_ch.saturated)
	);

`ifndef SYNTHESIS
	a_term_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready && in_ch.char_code == CH_NUL |=> !in_ch.ready)
		else $error("terminator beat did not start result build");

	a_int_only_for_int: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.number_kind != KIND_INT |-> out_ch.int_value == 0)
		else $error("integer value set on non-integer result");

	a_real_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.number_kind != KIND_REAL
		|-> out_ch.significand == 0 && out_ch.power_exponent == 0)
		else $error("real fields set on non-real result");

	a_nan_not_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.number_kind == KIND_NAN |-> !out_ch.saturated)
		else $error("illegal string reported as saturated");
`endif

endmodule

// File: tb/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import ntp_pkg::*;

	localparam longint unsigned INT_CAP = 64'h1_0000_0000;
	localparam int STALL_LIMIT = 2000;
	localparam int SEGMENT_CHARS = 36;
	localparam int MAX_REPORTS = 30;

	typedef logic [7:0] char_q_t[$];

	typedef struct {
		ntp_kind_t          kind;
		logic               neg;
		logic signed [31:0] ival;
		logic [63:0]        sig;
		logic signed [12:0] pexp;
		logic               sat;
	} number_t;

	class NumberScoreboard;
		logic [RADIX_W-1:0] radix;
		bit                 first_char;
		bit                 minus_sign;
		bit                 has_point;
		bit                 has_exp;
		bit                 after_marker;
		bit                 exp_minus;
		bit                 illegal;
		logic [63:0]        mantissa;
		int unsigned        exp_count;
		int unsigned        frac_count;
		bit                 clipped;
		number_t            pending_numbers[$];
		int                 errors;

		function new();
			radix = RADIX_RESET;
			errors = 0;
			restart();
		endfunction

		function void restart();
			first_char = 1;
			minus_sign = 0;
			has_point = 0;
			has_exp = 0;
			after_marker = 0;
			exp_minus = 0;
			illegal = 0;
			mantissa = '0;
			exp_count = 0;
			frac_count = 0;
			clipped = 0;
		endfunction

		function void set_radix(logic [RADIX_W-1:0] r);
			radix = r;
		endfunction

		function int outstanding();
			return pending_numbers.size();
		endfunction

		function int digit_value(logic [7:0] ch);
			int v;
			if (ch >= CH_ZERO && ch <= CH_NINE) begin
				v = ch - CH_ZERO;
			end else if (ch >= CH_A_UP && ch <= CH_Z_UP) begin
				v = ch - CH_A_UP + 10;
			end else if (ch >= CH_A_LO && ch <= CH_Z_LO) begin
				v = ch - CH_A_LO + 10;
			end else begin
				return -1;
			end
			return (v < radix) ? v : -1;
		endfunction

		function number_t finish_number();
			number_t r;
			longint unsigned m;
			int p;
			int unsigned i;
			r.kind = KIND_INT;
			r.neg = minus_sign;
			r.ival = '0;
			r.sig = '0;
			r.pexp = '0;
			r.sat = 0;
			if (illegal) begin
				r.kind = KIND_NAN;
			end else if (has_point) begin
				r.kind = KIND_REAL;
				r.sat = clipped;
				p = (exp_minus ? -int'(exp_count) : int'(exp_count)) - int'(frac_count);
				if (p > PEXP_MAX) begin
					p = PEXP_MAX;
					r.sat = 1;
				end
				if (p < -PEXP_MAX) begin
					p = -PEXP_MAX;
					r.sat = 1;
				end
				r.sig = mantissa;
				r.pexp = p[12:0];
			end else begin
				r.sat = clipped;
				m = mantissa;
				if (m > INT_CAP) m = INT_CAP;
				// positive exponent scales the integer until the exponent count runs out or it hits zero or the cap
				if (has_exp) begin
					for (i = 0; i < exp_count && m != 0 && m < INT_CAP; i++) begin
						m = m * radix;
						if (m > INT_CAP) m = INT_CAP;
					end
				end
				if (minus_sign) begin
					if (m > 64'h8000_0000) begin
						m = 64'h8000_0000;
						r.sat = 1;
					end
					r.ival = 32'd0 - m[31:0];
				end else begin
					if (m > 64'h7FFF_FFFF) begin
						m = 64'h7FFF_FFFF;
						r.sat = 1;
					end
					r.ival = m[31:0];
				end
			end
			return r;
		endfunction

		function void note_char(logic [7:0] ch);
			bit just;
			int d;
			logic [71:0] wide;
			int unsigned t;
			if (ch == CH_NUL) begin
				pending_numbers.push_back(finish_number());
				restart();
				return;
			end
			if (illegal) return;
			if (first_char) begin
				first_char = 0;
				if (ch == CH_MINUS) begin
					minus_sign = 1;
					return;
				end
				if (ch == CH_PLUS) return;
			end
			just = after_marker;
			after_marker = 0;
			if (ch == CH_POINT && !has_point && !has_exp) begin
				has_point = 1;
			end else if (!has_exp && (ch == CH_E_LO || ch == CH_E_UP ||
					ch == CH_D_LO || ch == CH_D_UP)) begin
				has_exp = 1;
				after_marker = 1;
			end else if (has_exp && just && ch == CH_MINUS) begin
				exp_minus = 1;
				has_point = 1;
			end else if (has_exp && just && ch == CH_PLUS) begin
				exp_minus = 0;
			end else begin
				d = digit_value(ch);
				if (d < 0) begin
					illegal = 1;
				end else if (!has_exp) begin
					wide = {8'd0, mantissa} * radix + d;
					if (|wide[71:64]) begin
						mantissa = '1;
						clipped = 1;
					end else begin
						mantissa = wide[63:0];
					end
					if (has_point) begin
						if (frac_count >= EXP_LIMIT_DEF) clipped = 1;
						else frac_count++;
					end
				end else begin
					t = exp_count * radix + d;
					if (t > EXP_LIMIT_DEF) begin
						t = EXP_LIMIT_DEF;
						clipped = 1;
					end
					exp_count = t;
				end
			end
		endfunction

		function void check_number(number_t got);
			number_t want;
			bit bad;
			if (pending_numbers.size() == 0) begin
				errors++;
				$display("%0t: result beat with nothing expected (kind %0d)", $time, got.kind);
				return;
			end
			want = pending_numbers.pop_front();
			bad = (got.kind !== want.kind) || (got.neg !== want.neg) ||
				(got.ival !== want.ival) || (got.sig !== want.sig) ||
				(got.pexp !== want.pexp) || (got.sat !== want.sat);
			if (!bad) return;
			errors++;
			if (errors > MAX_REPORTS) return;
			if (got.kind !== want.kind)
				$display("%0t: number_kind expected %0d got %0d", $time, want.kind, got.kind);
			if (got.neg !== want.neg)
				$display("%0t: is_negative expected %0b got %0b", $time, want.neg, got.neg);
			if (got.ival !== want.ival)
				$display("%0t: int_value expected %0d got %0d", $time, want.ival, got.ival);
			if (got.sig !== want.sig)
				$display("%0t: significand expected %0h got %0h", $time, want.sig, got.sig);
			if (got.pexp !== want.pexp)
				$display("%0t: power_exponent expected %0d got %0d", $time, want.pexp, got.pexp);
			if (got.sat !== want.sat)
				$display("%0t: saturated expected %0b got %0b", $time, want.sat, got.sat);
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               radix_we;
	logic [RADIX_W-1:0] radix_wdata;

	ntp_in_if  in_ch();
	ntp_out_if out_ch();

	numeric_text_to_number_parser DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.radix_we   (radix_we),
		.radix_wdata(radix_wdata),
		.in_ch      (in_ch),
		.out_ch     (out_ch)
	);

	NumberScoreboard sb = new();
	int send_idle_pct = 11;
	int recv_idle_pct = 71;
	int chars_sent = 0;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// result side: random backpressure, check every beat
	initial begin
		number_t got;
		out_ch.ready = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_ch.valid && out_ch.ready) begin
				got.kind = ntp_kind_t'(out_ch.number_kind);
				got.neg = out_ch.is_negative;
				got.ival = out_ch.int_value;
				got.sig = out_ch.significand;
				got.pexp = out_ch.power_exponent;
				got.sat = out_ch.saturated;
				sb.check_number(got);
			end
			@(negedge clk);
			out_ch.ready = (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
		end
	end

	initial begin
		int stalled;
		stalled = 0;
		forever begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) stalled = 0;
			else stalled++;
			if (stalled >= STALL_LIMIT) begin
				$display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	task automatic send_char(input logic [7:0] ch);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_ch.valid = 0;
			@(negedge clk);
		end
		in_ch.valid = 1;
		in_ch.char_code = ch;
		do @(posedge clk); while (!in_ch.ready);
		sb.note_char(ch);
		chars_sent++;
		@(negedge clk);
	endtask

	task automatic send_string(input char_q_t s);
		foreach (s[i]) send_char(s[i]);
	endtask

	task automatic send_text(input string txt);
		for (int i = 0; i < txt.len(); i++) send_char(txt[i]);
		send_char(CH_NUL);
	endtask

	task automatic wait_for_results();
		in_ch.valid = 0;
		while (sb.outstanding() != 0) @(negedge clk);
	endtask

	task automatic drain_and_set_radix(input logic [RADIX_W-1:0] r);
		wait_for_results();
		// let the parser go quiet before the register write
		repeat (40) @(negedge clk);
		radix_we = 1;
		radix_wdata = r;
		@(negedge clk);
		radix_we = 0;
		sb.set_radix(r);
	endtask

	function automatic logic [7:0] digit_char(input int unsigned v);
		if (v < 10) return CH_ZERO + 8'(v);
		return ($urandom_range(1) ? CH_A_UP : CH_A_LO) + 8'(v - 10);
	endfunction

	function automatic logic [7:0] pick_marker();
		case ($urandom_range(3))
			0: return CH_E_LO;
			1: return CH_E_UP;
			2: return CH_D_LO;
			default: return CH_D_UP;
		endcase
	endfunction

	function automatic char_q_t make_number(input int unsigned rdx);
		char_q_t s;
		int unsigned style, len, pos, k;
		bit zeros;
		style = $urandom_range(99);
		if (style < 75) begin
			case ($urandom_range(3))
				0: s.push_back(CH_MINUS);
				1: s.push_back(CH_PLUS);
				default: ;
			endcase
			// mostly short mantissas, now and then long enough to overflow
			len = ($urandom_range(99) < 8) ? $urandom_range(12, 70) : $urandom_range(0, 6);
			zeros = ($urandom_range(9) == 0);
			pos = ($urandom_range(99) < 40) ? $urandom_range(0, len) : len + 1;
			for (k = 0; k <= len; k++) begin
				if (k == pos) s.push_back(CH_POINT);
				if (k < len) s.push_back(zeros ? CH_ZERO : digit_char($urandom_range(rdx - 1)));
			end
			if ($urandom_range(99) < 45) begin
				s.push_back(pick_marker());
				case ($urandom_range(2))
					0: s.push_back(CH_MINUS);
					1: s.push_back(CH_PLUS);
					default: ;
				endcase
				len = ($urandom_range(9) == 0) ? $urandom_range(4, 7) : $urandom_range(0, 2);
				for (k = 0; k < len; k++) s.push_back(digit_char($urandom_range(rdx - 1)));
			end
		end else if (style < 90) begin
			len = $urandom_range(1, 8);
			repeat (len) begin
				case ($urandom_range(4))
					0: s.push_back($urandom_range(1) ? CH_MINUS : CH_PLUS);
					1: s.push_back(CH_POINT);
					2: s.push_back(pick_marker());
					default: s.push_back(digit_char($urandom_range(35)));
				endcase
			end
		end else begin
			len = $urandom_range(1, 6);
			repeat (len) s.push_back(8'($urandom_range(1, 255)));
		end
		s.push_back(CH_NUL);
		return s;
	endfunction

	initial begin
		logic [RADIX_W-1:0] plan[12];
		char_q_t text;
		int seg_start;

		plan = '{6'd36, 6'd2, 6'd16, 6'd10, 6'd8, 6'd13,
			6'd14, 6'd36, 6'd2, 6'd25, 6'd10, 6'd7};
		arst_n = 0;
		radix_we = 0;
		radix_wdata = RADIX_RESET;
		in_ch.valid = 0;
		in_ch.char_code = CH_NUL;
		repeat (3) @(negedge clk);
		arst_n = 1;

		// directed strings at the reset radix
		send_text("");
		send_text("+");
		send_text("d");
		send_text(".");
		send_text("1e-3");
		send_text("-7E+2");
		send_text("1-");
		send_char(CH_ZERO + 8'd5);
		send_char(8'hFF);
		send_char(8'h80);
		send_char(CH_NUL);

		for (int seg = 0; seg < 12; seg++) begin
			drain_and_set_radix(plan[seg]);
			case (seg / 4)
				0: begin
					send_idle_pct = 11;
					recv_idle_pct = 71;
				end
				1: begin
					send_idle_pct = 71;
					recv_idle_pct = 11;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			if (seg == 8) begin
				// fraction long enough to saturate the digit count
				text.delete();
				text.push_back(CH_POINT);
				repeat (EXP_LIMIT_DEF + 6) text.push_back(digit_char($urandom_range(plan[seg] - 1)));
				text.push_back(CH_NUL);
				send_string(text);
			end
			seg_start = chars_sent;
			while (chars_sent - seg_start < SEGMENT_CHARS) begin
				send_string(make_number(plan[seg]));
				if ($urandom_range(29) == 0) wait_for_results();
			end
		end

		wait_for_results();
		repeat (60) @(negedge clk);
		if (sb.errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end
endmodule
